/* hdl/kpq_pkg.sv */
// ----------------------------------------------------------------------------
// kpq_pkg: shared types and constants of the keyed priority queue
// Slot capacity, request and status codes, and the structs that carry slot
// reads, write-back commands and scan results between the modules.
// ----------------------------------------------------------------------------
package kpq_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned ARR_W    = 32;
  localparam int unsigned PRIO_W   = 2;

  typedef enum logic [1:0] {
    REQ_REGISTER = 2'd0,
    REQ_SET_PRIO = 2'd1,
    REQ_SERVE    = 2'd2,
    REQ_LOOKUP   = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_DUP       = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_BAD_PRIO  = 3'd3,
    ST_EMPTY     = 3'd4,
    ST_FULL      = 3'd5
  } status_e;

  localparam logic [PRIO_W-1:0] PRIO_NONE   = 2'd0;
  localparam logic [PRIO_W-1:0] PRIO_HIGH   = 2'd1;
  localparam logic [PRIO_W-1:0] PRIO_MEDIUM = 2'd2;
  localparam logic [PRIO_W-1:0] PRIO_LOW    = 2'd3;

  localparam logic [ARR_W-1:0] COUNTER_LAST = '1;

  // One slot as read from the store
  typedef struct packed {
    logic              valid;
    logic [KEY_W-1:0]  key;
    logic [PRIO_W-1:0] prio;
    logic [ARR_W-1:0]  arrival;
  } kpq_slot_t;

  // Write-back command to the store
  typedef struct packed {
    logic              insert;
    logic              set_prio;
    logic              clear;
    logic [IDX_W-1:0]  idx;
    logic [KEY_W-1:0]  key;
    logic [PRIO_W-1:0] prio;
    logic [ARR_W-1:0]  arrival;
  } kpq_wr_t;

  // Accumulated outcome of one pass over the slots
  typedef struct packed {
    logic              hit;
    logic [IDX_W-1:0]  hit_idx;
    logic [PRIO_W-1:0] hit_prio;
    logic              free;
    logic [IDX_W-1:0]  free_idx;
    logic              best;
    logic [IDX_W-1:0]  best_idx;
    logic [KEY_W-1:0]  best_key;
    logic [PRIO_W-1:0] best_prio;
  } kpq_scan_t;

endpackage

/* hdl/keyed_priority_queue.sv */
// ----------------------------------------------------------------------------
// keyed_priority_queue: bounded queue of keyed entries
// Sequencer around the slot store and a shared slot comparator.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one request: register an
//   ID, set the priority of an ID, serve the best entry, or look up an ID.
//   Output channel (out_valid_o / out_stall_i) carries exactly one result per
//   request: a status code, plus key and priority for serve and look up.
//   Each request is taken, then walks the slots (CAPACITY = 16) in order
//   through the single comparator, then writes back and loads the result
//   register. in_stall_o is high from transfer to write-back.
//   The result is valid from the cycle after write-back, which is also the
//   first cycle in which the next request can be taken.
//   While the receiver stalls, the result holds in the output register; a
//   following request still runs its scan and waits at write-back until the
//   earlier result has been transferred.
//   Reset clears all slot valid bits and the arrival counter; slot contents
//   need no clearing pass.
// ----------------------------------------------------------------------------
module keyed_priority_queue
  import kpq_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               req_type_i,
  input  logic signed [KEY_W-1:0]  ticket_key_i,
  input  logic [PRIO_W-1:0]        priority_code_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [2:0]               status_o,
  output logic signed [KEY_W-1:0]  result_key_o,
  output logic [PRIO_W-1:0]        result_priority_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_e;

  state_e              state_q;
  logic [IDX_W-1:0]    idx_q;
  req_e                req_q;
  logic [KEY_W-1:0]    key_q;
  logic [PRIO_W-1:0]   prio_q;
  logic [ARR_W-1:0]    ctr_q;
  logic                out_valid_q;
  status_e             status_q;
  logic [KEY_W-1:0]    rkey_q;
  logic [PRIO_W-1:0]   rprio_q;

  logic                accept;
  logic                advance;
  logic                last_idx;
  kpq_slot_t           slot;
  kpq_scan_t           scan;
  kpq_wr_t             wr;
  logic [CAPACITY-1:0] valid_vec;
  status_e             status_d;
  logic [KEY_W-1:0]    rkey_d;
  logic [PRIO_W-1:0]   rprio_d;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign last_idx   = (idx_q == IDX_W'(CAPACITY - 1));
  assign advance    = (state_q == S_FINISH) && (!out_valid_q || !out_stall_i);

  kpq_store u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_idx_i (idx_q),
    .rd_o     (slot),
    .wr_i     (wr),
    .valid_o  (valid_vec)
  );

  kpq_scan u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .step_i  (state_q == S_SCAN),
    .idx_i   (idx_q),
    .key_i   (key_q),
    .slot_i  (slot),
    .res_o   (scan)
  );

  // Decide the outcome and the write-back from the scan results
  always_comb begin
    status_d    = ST_OK;
    rkey_d      = '0;
    rprio_d     = PRIO_NONE;
    wr          = '0;
    wr.key      = key_q;
    wr.arrival  = ctr_q;
    unique case (req_q)
      REQ_REGISTER: begin
        if (scan.hit) begin
          status_d = ST_DUP;
        end else if (!scan.free || ctr_q == COUNTER_LAST) begin
          status_d = ST_FULL;
        end else begin
          wr.insert = advance;
          wr.idx    = scan.free_idx;
          wr.prio   = PRIO_LOW;
        end
      end
      REQ_SET_PRIO: begin
        if (!scan.hit) begin
          status_d = ST_NOT_FOUND;
        end else if (prio_q == PRIO_NONE) begin
          status_d = ST_BAD_PRIO;
        end else begin
          wr.set_prio = advance;
          wr.idx      = scan.hit_idx;
          wr.prio     = prio_q;
        end
      end
      REQ_SERVE: begin
        if (!scan.best) begin
          status_d = ST_EMPTY;
        end else begin
          rkey_d   = scan.best_key;
          rprio_d  = scan.best_prio;
          wr.clear = advance;
          wr.idx   = scan.best_idx;
        end
      end
      REQ_LOOKUP: begin
        if (!scan.hit) begin
          status_d = ST_NOT_FOUND;
        end else begin
          rkey_d  = key_q;
          rprio_d = scan.hit_prio;
        end
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
  end

  // Sequencer: take request, walk slots, write back and load result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      req_q       <= REQ_REGISTER;
      key_q       <= '0;
      prio_q      <= PRIO_NONE;
      ctr_q       <= '0;
      out_valid_q <= 1'b0;
      status_q    <= ST_OK;
      rkey_q      <= '0;
      rprio_q     <= PRIO_NONE;
    end else begin
      // Raise on write-back, drop once the result is transferred
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            req_q   <= req_e'(req_type_i);
            key_q   <= ticket_key_i;
            prio_q  <= priority_code_i;
            idx_q   <= '0;
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (last_idx) begin
            state_q <= S_FINISH;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        S_FINISH: begin
          if (advance) begin
            status_q    <= status_d;
            rkey_q      <= rkey_d;
            rprio_q     <= rprio_d;
            if (wr.insert) begin
              ctr_q <= ctr_q + 1'b1;
            end
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = status_q;
  assign result_key_o      = rkey_q;
  assign result_priority_o = rprio_q;

  // Arrival counter only holds or counts up by one
  a_ctr_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (ctr_q == $past(ctr_q) || ctr_q == $past(ctr_q) + 1'b1))
    else $error("arrival counter moved by more than one");

  // Slot occupancy changes only at write-back
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_FINISH |=> valid_vec == $past(valid_vec))
    else $error("slot valid bits changed outside write-back");

  // Failed requests carry zero result fields
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_OK) |-> (result_key_o == '0 && result_priority_o == '0))
    else $error("failed request returned non-zero result fields");

  // A new result only appears after write-back
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == S_FINISH)
    else $error("result raised outside write-back");

endmodule

/* hdl/kpq_store.sv */
// ----------------------------------------------------------------------------
// kpq_store: slot storage
// Holds key, priority and arrival number of every slot with a valid bit per
// slot. One read port at the scan index, one write-back port.
// ----------------------------------------------------------------------------
module kpq_store
  import kpq_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [IDX_W-1:0]    rd_idx_i,
  output kpq_slot_t           rd_o,
  input  kpq_wr_t             wr_i,
  output logic [CAPACITY-1:0] valid_o
);

  logic [CAPACITY-1:0] valid_q;
  logic [KEY_W-1:0]    key_q  [CAPACITY];
  logic [PRIO_W-1:0]   prio_q [CAPACITY];
  logic [ARR_W-1:0]    arr_q  [CAPACITY];

  // Valid bits: set on insert, drop on serve
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_i.insert) begin
      valid_q[wr_i.idx] <= 1'b1;
    end else if (wr_i.clear) begin
      valid_q[wr_i.idx] <= 1'b0;
    end
  end

  // Payload: no reset, only read behind a valid bit
  always_ff @(posedge clk_i) begin
    if (wr_i.insert) begin
      key_q[wr_i.idx]  <= wr_i.key;
      prio_q[wr_i.idx] <= wr_i.prio;
      arr_q[wr_i.idx]  <= wr_i.arrival;
    end else if (wr_i.set_prio) begin
      prio_q[wr_i.idx] <= wr_i.prio;
    end
  end

  assign rd_o.valid   = valid_q[rd_idx_i];
  assign rd_o.key     = key_q[rd_idx_i];
  assign rd_o.prio    = prio_q[rd_idx_i];
  assign rd_o.arrival = arr_q[rd_idx_i];
  assign valid_o      = valid_q;

endmodule

/* hdl/kpq_scan.sv */
// ----------------------------------------------------------------------------
// kpq_scan: shared slot comparator
// Looks at one slot per cycle and keeps the key match, the lowest free slot
// and the best entry (lowest priority number, then oldest arrival).
// ----------------------------------------------------------------------------
module kpq_scan
  import kpq_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             step_i,
  input  logic [IDX_W-1:0] idx_i,
  input  logic [KEY_W-1:0] key_i,
  input  kpq_slot_t        slot_i,
  output kpq_scan_t        res_o
);

  kpq_scan_t        res_q;
  logic [ARR_W-1:0] best_arr_q;
  logic             key_eq;
  logic             better;

  // Single compare unit: key match and ordered priority/arrival compare
  assign key_eq = (slot_i.key == key_i);
  assign better = !res_q.best ||
                  ({slot_i.prio, slot_i.arrival} < {res_q.best_prio, best_arr_q});

  // Clear the flags on start, accumulate flags and payload on every step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q      <= '0;
      best_arr_q <= '0;
    end else if (start_i) begin
      res_q.hit  <= 1'b0;
      res_q.free <= 1'b0;
      res_q.best <= 1'b0;
    end else if (step_i) begin
      if (slot_i.valid && key_eq && !res_q.hit) begin
        res_q.hit      <= 1'b1;
        res_q.hit_idx  <= idx_i;
        res_q.hit_prio <= slot_i.prio;
      end
      if (!slot_i.valid && !res_q.free) begin
        res_q.free     <= 1'b1;
        res_q.free_idx <= idx_i;
      end
      if (slot_i.valid && better) begin
        res_q.best      <= 1'b1;
        res_q.best_idx  <= idx_i;
        res_q.best_key  <= slot_i.key;
        res_q.best_prio <= slot_i.prio;
        best_arr_q      <= slot_i.arrival;
      end
    end
  end

  assign res_o = res_q;

endmodule

/* tb/keyed_priority_queue_test.sv */
// ----------------------------------------------------------------------------
// keyed_priority_queue_test: self-checking bench for the keyed priority queue
// Drives register, set-priority, serve and look-up requests through the
// valid/stall input channel and predicts each result from a behavioural copy
// of the slot store and arrival counter. It opens with a directed pass over
// the key extremes and error codes, then issues random requests from a small
// key pool that drifts between filling and draining. The sender idles in
// bursts and the receiver stalls in shifting patterns.
// ----------------------------------------------------------------------------
module keyed_priority_queue_test
  import kpq_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned RANDOM_REQS = 1950;
  localparam int unsigned POOL_SIZE   = 24;
  localparam int unsigned TAIL_CYCLES = 40;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_LONG
  } stall_mode_e;

  typedef struct {
    status_e                   status;
    logic signed [KEY_W-1:0]   key;
    logic        [PRIO_W-1:0]  prio;
  } ticket_result_t;

  // Behavioural copy of the queue plus the list of results still owed
  class ticket_scoreboard;
    bit                       slot_used[CAPACITY];
    logic signed [KEY_W-1:0]  slot_id[CAPACITY];
    logic        [PRIO_W-1:0] slot_rank[CAPACITY];
    logic        [ARR_W-1:0]  slot_seq[CAPACITY];
    logic        [ARR_W-1:0]  next_arrival;
    ticket_result_t           owed_results[$];
    int unsigned              mismatches;

    function new();
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      next_arrival = '0;
      mismatches   = 0;
    endfunction

    function int unsigned outstanding();
      return owed_results.size();
    endfunction

    task report_mismatch(string msg);
      $display("mismatch: %s", msg);
      mismatches++;
    endtask

    // Apply one accepted request to the copy and queue its result
    function void note_request(req_e req, logic signed [KEY_W-1:0] key,
                               logic [PRIO_W-1:0] code);
      ticket_result_t res;
      int             hit;
      int             free_idx;
      int             best;
      res.status = ST_OK;
      res.key    = '0;
      res.prio   = PRIO_NONE;
      hit        = -1;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
        if (slot_used[i] && slot_id[i] == key) hit = i;
      end
      case (req)
        REQ_REGISTER: begin
          free_idx = -1;
          for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (!slot_used[i]) free_idx = i;
          end
          // duplicate check wins over the full check
          if (hit >= 0) begin
            res.status = ST_DUP;
          end else if (free_idx < 0 || next_arrival == COUNTER_LAST) begin
            res.status = ST_FULL;
          end else begin
            slot_used[free_idx] = 1'b1;
            slot_id[free_idx]   = key;
            slot_rank[free_idx] = PRIO_LOW;
            slot_seq[free_idx]  = next_arrival;
            next_arrival        = next_arrival + 1'b1;
          end
        end
        REQ_SET_PRIO: begin
          if (hit < 0) begin
            res.status = ST_NOT_FOUND;
          end else if (code == PRIO_NONE) begin
            res.status = ST_BAD_PRIO;
          end else begin
            slot_rank[hit] = code;
          end
        end
        REQ_SERVE: begin
          // lowest priority number first, then oldest arrival
          best = -1;
          for (int i = 0; i < CAPACITY; i++) begin
            if (slot_used[i] &&
                (best < 0 || slot_rank[i] < slot_rank[best] ||
                 (slot_rank[i] == slot_rank[best] && slot_seq[i] < slot_seq[best])))
              best = i;
          end
          if (best < 0) begin
            res.status = ST_EMPTY;
          end else begin
            res.key         = slot_id[best];
            res.prio        = slot_rank[best];
            slot_used[best] = 1'b0;
          end
        end
        default: begin
          if (hit < 0) begin
            res.status = ST_NOT_FOUND;
          end else begin
            res.key  = slot_id[hit];
            res.prio = slot_rank[hit];
          end
        end
      endcase
      owed_results.push_back(res);
    endfunction

    // Compare one transferred result against the oldest owed one
    task check_result(logic [2:0] status, logic signed [KEY_W-1:0] key,
                      logic [PRIO_W-1:0] prio);
      ticket_result_t exp;
      if (owed_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result status=%0d key=%0d prio=%0d",
                                  status, key, prio));
      end else begin
        exp = owed_results.pop_front();
        if (status !== exp.status)
          report_mismatch($sformatf("status %0d, expected %s", status,
                                    exp.status.name()));
        if (key !== exp.key)
          report_mismatch($sformatf("result key %0d, expected %0d", key, exp.key));
        if (prio !== exp.prio)
          report_mismatch($sformatf("result priority %0d, expected %0d", prio,
                                    exp.prio));
      end
    endtask
  endclass

  logic                     clk_i           = 1'b0;
  logic                     rst_ni          = 1'b0;
  logic                     in_valid_i      = 1'b0;
  logic                     in_stall_o;
  logic [1:0]               req_type_i      = '0;
  logic signed [KEY_W-1:0]  ticket_key_i    = '0;
  logic [PRIO_W-1:0]        priority_code_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i     = 1'b0;
  logic [2:0]               status_o;
  logic signed [KEY_W-1:0]  result_key_o;
  logic [PRIO_W-1:0]        result_priority_o;

  int unsigned      cycle_count = 0;
  int unsigned      burst_left  = 0;
  stall_mode_e      stall_mode  = STALL_NONE;
  ticket_scoreboard ticket_sb   = new();

  keyed_priority_queue u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .req_type_i        (req_type_i),
    .ticket_key_i      (ticket_key_i),
    .priority_code_i   (priority_code_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .status_o          (status_o),
    .result_key_o      (result_key_o),
    .result_priority_o (result_priority_o)
  );

  // Clock generation
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Count cycles and abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver back-pressure: one of four stall patterns, re-chosen at random
  always @(posedge clk_i) begin
    if (cycle_count % 256 == 0) stall_mode <= stall_mode_e'($urandom_range(0, 3));
    case (stall_mode)
      STALL_NONE:  out_stall_i <= 1'b0;
      STALL_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall_i <= ($urandom_range(0, 3) != 0);
      default:     out_stall_i <= (cycle_count % 64) < 40;
    endcase
  end

  // Check every result transfer
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      ticket_sb.check_result(status_o, result_key_o, result_priority_o);
  end

  // Present one request, pacing the sender in bursts, and hold it until taken
  task automatic issue(req_e req, logic signed [KEY_W-1:0] key,
                       logic [PRIO_W-1:0] code);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i      <= 1'b1;
    req_type_i      <= req;
    ticket_key_i    <= key;
    priority_code_i <= code;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    ticket_sb.note_request(req, key, code);
  endtask

  // Hold off the sender until every owed result has been transferred
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (ticket_sb.outstanding() != 0) @(posedge clk_i);
  endtask

  // Stimulus
  initial begin
    logic signed [KEY_W-1:0] key_pool[POOL_SIZE];
    logic signed [KEY_W-1:0] key;
    bit                      filling;
    int unsigned             pick;
    req_e                    req;

    key_pool[0] = 32'sh0000_0000;
    key_pool[1] = -32'sd1;
    key_pool[2] = 32'sh7FFF_FFFF;
    key_pool[3] = 32'sh8000_0000;
    for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom;
    filling = 1'b1;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty queue, absent keys, key extremes, error ordering, full
    issue(REQ_SERVE,    $urandom, PRIO_W'($urandom_range(0, 3)));
    issue(REQ_LOOKUP,   32'sh0000_0000, PRIO_HIGH);
    issue(REQ_SET_PRIO, 32'sh7FFF_FFFF, PRIO_NONE);
    issue(REQ_REGISTER, 32'sh7FFF_FFFF, PRIO_NONE);
    issue(REQ_REGISTER, 32'sh8000_0000, PRIO_LOW);
    issue(REQ_REGISTER, -32'sd1,        PRIO_HIGH);
    issue(REQ_REGISTER, 32'sh0000_0000, PRIO_MEDIUM);
    issue(REQ_REGISTER, 32'sh7FFF_FFFF, PRIO_HIGH);
    issue(REQ_SET_PRIO, 32'sh8000_0000, PRIO_NONE);
    issue(REQ_SET_PRIO, -32'sd1,        PRIO_HIGH);
    issue(REQ_SET_PRIO, 32'sh0000_0000, PRIO_MEDIUM);
    issue(REQ_LOOKUP,   -32'sd1,        PRIO_NONE);
    issue(REQ_SERVE,    32'sh0000_0000, PRIO_LOW);
    for (int i = 0; i < CAPACITY - 3; i++)
      issue(REQ_REGISTER, 32'sh0000_1000 + i, PRIO_W'($urandom_range(0, 3)));
    issue(REQ_REGISTER, 32'sh5A5A_A5A5,  PRIO_LOW);
    issue(REQ_REGISTER, 32'sh8000_0000, PRIO_LOW);
    drain_results();

    // Random: pool keys for hits and duplicates, phases that fill or drain
    for (int n = 0; n < RANDOM_REQS; n++) begin
      if ($urandom_range(0, 79) == 0) begin
        filling = !filling;
        key_pool[$urandom_range(4, POOL_SIZE - 1)] = $urandom;
      end
      pick = $urandom_range(0, 99);
      if (filling)
        req = (pick < 50) ? REQ_REGISTER : (pick < 70) ? REQ_SET_PRIO :
              (pick < 80) ? REQ_SERVE : REQ_LOOKUP;
      else
        req = (pick < 15) ? REQ_REGISTER : (pick < 35) ? REQ_SET_PRIO :
              (pick < 75) ? REQ_SERVE : REQ_LOOKUP;
      key = ($urandom_range(0, 6) == 0) ? $urandom
                                        : key_pool[$urandom_range(0, POOL_SIZE - 1)];
      issue(req, key, PRIO_W'($urandom_range(0, 3)));
      if (n % 500 == 499) drain_results();
    end

    // Wind down and give the verdict
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (ticket_sb.mismatches == 0 && ticket_sb.outstanding() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
